// File: rtl/sliding_window_median_macros.svh
// Assertion macros shared by the sliding window median RTL.
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

`ifndef ASSERT_OFF

// Plain property check, disabled while reset is asserted
`define SWM_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("sliding window median check failed");

// Same-cycle implication check
`define SWM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("sliding window median implication failed");

// Next-cycle implication check
`define SWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("sliding window median next-cycle check failed");

`else

`define SWM_ASSERT(lbl, clk, rstn, prop)
`define SWM_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/swm_pkg.sv
// Shared constants and types for the sliding window median filter.
package swm_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// window_size register
	localparam int                 CFG_BITS = 7;
	localparam logic [CFG_BITS-1:0] WS_RESET = 7'd3;

	// cells per first-level selection group
	localparam int GROUP_SIZE = 8;

	// commands broadcast to every cell of the row
	typedef struct packed {
		logic ins;    // insert the new sample in sorted position
		logic evict;  // drop the cell holding the oldest tag, close the gap
	} cell_cmd_t;

endpackage

// File: rtl/swm_cell.sv
// One cell of the sorted window row: holds a sample and its arrival slot tag.
module swm_cell #(
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
	parameter int TAG_BITS    = 6,
	parameter int CNT_BITS    = 7,
	parameter int IDX         = 0
) (
	input  logic                          clk,
	input  swm_pkg::cell_cmd_t            cmd,
	input  logic        [CNT_BITS-1:0]    count,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic        [TAG_BITS-1:0]    new_tag,
	input  logic        [TAG_BITS-1:0]    oldest,
	input  logic                          prev_gt,
	input  logic signed [SAMPLE_BITS-1:0] prev_value,
	input  logic        [TAG_BITS-1:0]    prev_tag,
	input  logic signed [SAMPLE_BITS-1:0] next_value,
	input  logic        [TAG_BITS-1:0]    next_tag,
	input  logic                          found_in,
	input  logic        [CNT_BITS-1:0]    lo_idx,
	input  logic        [CNT_BITS-1:0]    hi_idx,
	output logic signed [SAMPLE_BITS-1:0] value,
	output logic        [TAG_BITS-1:0]    tag,
	output logic                          gt,
	output logic                          found_out,
	output logic        [SAMPLE_BITS-1:0] lo_sel,
	output logic        [SAMPLE_BITS-1:0] hi_sel
);
	import swm_pkg::*;

	localparam logic [CNT_BITS-1:0] MY_IDX = CNT_BITS'(IDX);

	logic signed [SAMPLE_BITS-1:0] value_q;
	logic        [TAG_BITS-1:0]    tag_q;
	logic                          occupied;
	logic                          match;

	assign occupied = MY_IDX < count;

	// sorted insert: larger held values move one cell up
	assign gt = occupied && (value_q > sample);

	// eviction: the found flag ripples up from the cell holding the oldest tag
	assign match     = occupied && (tag_q == oldest);
	assign found_out = found_in | match;

	// median tap, zero unless this cell is the selected rank
	assign lo_sel = (MY_IDX == lo_idx) ? value_q : '0;
	assign hi_sel = (MY_IDX == hi_idx) ? value_q : '0;

	assign value = value_q;
	assign tag   = tag_q;

	// value and tag update
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (prev_gt) begin
				value_q <= prev_value;
				tag_q   <= prev_tag;
			end else if (gt || (MY_IDX == count)) begin
				value_q <= sample;
				tag_q   <= new_tag;
			end
		end else if (cmd.evict && found_out) begin
			value_q <= next_value;
			tag_q   <= next_tag;
		end
	end

endmodule

// File: rtl/sliding_window_median.sv
// Top level of the sliding window median filter: control, cell row and median output.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------
//  input    | in_valid / in_ready    | sample, restart
//  output   | out_valid / out_ready  | median_x2
//  config   | cfg_valid / cfg_ready  | cfg_data (window_size)
//
// A sample that completes a window passes through insert, rank select and emit
// with eviction; one that only fills passes through insert and rank select.
// The emit step waits while the output register holds an untaken result;
// the next sample is taken as soon as the emit is done.
// Reset clears the fill count, oldest pointer, control and window_size (3);
// cell contents are not cleared, no clearing pass is run.
module sliding_window_median #(
	parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	input  logic                            restart,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [SAMPLE_BITS:0]     median_x2,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [swm_pkg::CFG_BITS-1:0]    cfg_data
);
	import swm_pkg::*;

	`include "sliding_window_median_macros.svh"

	localparam int CW      = $clog2(WINDOW_MAX + 1);
	localparam int PW      = $clog2(WINDOW_MAX);
	localparam int SW      = CW + 1;
	localparam int EW      = (CW > CFG_BITS) ? CW : CFG_BITS;
	localparam int NGROUPS = (WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE;

	localparam logic [1:0] ST_INSERT = 2'd0;
	localparam logic [1:0] ST_SELECT = 2'd1;
	localparam logic [1:0] ST_EMIT   = 2'd2;

	logic [1:0]          state_q;
	logic [CFG_BITS-1:0] ws_q;
	logic [CW-1:0]       count_q;
	logic [PW-1:0]       oldest_q;
	logic                out_valid_q;
	logic signed [SAMPLE_BITS:0] median_q;

	logic in_fire, emit_fire, out_free;

	// config write, taken whenever offered
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= WS_RESET;
		end else if (cfg_valid) begin
			ws_q <= cfg_data;
		end
	end

	// effective window size: zero reads as one, saturate at the row length
	logic [EW-1:0] ws_ext, k_ext, n_ext;
	logic          need_more;

	assign ws_ext    = EW'(ws_q);
	assign k_ext     = (ws_ext == '0) ? EW'(1) :
	                   ((ws_ext > EW'(WINDOW_MAX)) ? EW'(WINDOW_MAX) : ws_ext);
	assign n_ext     = EW'(count_q);
	assign need_more = n_ext < k_ext;

	// insert-side counts, restart empties the window first
	logic [CW-1:0] count_ins;
	logic [PW-1:0] oldest_ins;
	logic [SW-1:0] slot_sum, slot_wrap;
	logic [PW-1:0] new_tag;

	assign count_ins  = restart ? '0 : count_q;
	assign oldest_ins = restart ? '0 : oldest_q;
	assign slot_sum   = SW'(oldest_ins) + SW'(count_ins);
	assign slot_wrap  = (slot_sum >= SW'(WINDOW_MAX)) ? (slot_sum - SW'(WINDOW_MAX)) : slot_sum;
	assign new_tag    = slot_wrap[PW-1:0];

	// handshakes
	assign in_ready  = (state_q == ST_INSERT);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign emit_fire = (state_q == ST_EMIT) && out_free;

	// median ranks over the n held samples
	logic [CW-1:0] mid, lo_idx;
	assign mid    = count_q >> 1;
	assign lo_idx = count_q[0] ? mid : (mid - CW'(1));

	// cell row
	cell_cmd_t     cmd;
	logic [CW-1:0] cell_count;

	assign cmd.ins    = in_fire;
	assign cmd.evict  = emit_fire;
	assign cell_count = (state_q == ST_INSERT) ? count_ins : count_q;

	logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
	logic        [PW-1:0]          cell_tag   [WINDOW_MAX];
	logic                          cell_gt    [WINDOW_MAX];
	logic        [SAMPLE_BITS-1:0] cell_lo    [WINDOW_MAX];
	logic        [SAMPLE_BITS-1:0] cell_hi    [WINDOW_MAX];
	logic                          found      [WINDOW_MAX+1];

	assign found[0] = 1'b0;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic                          p_gt;
		logic signed [SAMPLE_BITS-1:0] p_value, n_value;
		logic        [PW-1:0]          p_tag, n_tag;

		if (i == 0) begin : g_first
			assign p_gt    = 1'b0;
			assign p_value = sample;
			assign p_tag   = new_tag;
		end else begin : g_mid
			assign p_gt    = cell_gt[i-1];
			assign p_value = cell_value[i-1];
			assign p_tag   = cell_tag[i-1];
		end

		if (i == WINDOW_MAX - 1) begin : g_last
			assign n_value = cell_value[i];
			assign n_tag   = cell_tag[i];
		end else begin : g_up
			assign n_value = cell_value[i+1];
			assign n_tag   = cell_tag[i+1];
		end

		swm_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.TAG_BITS    (PW),
			.CNT_BITS    (CW),
			.IDX         (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (cell_count),
			.sample     (sample),
			.new_tag    (new_tag),
			.oldest     (oldest_q),
			.prev_gt    (p_gt),
			.prev_value (p_value),
			.prev_tag   (p_tag),
			.next_value (n_value),
			.next_tag   (n_tag),
			.found_in   (found[i]),
			.lo_idx     (lo_idx),
			.hi_idx     (mid),
			.value      (cell_value[i]),
			.tag        (cell_tag[i]),
			.gt         (cell_gt[i]),
			.found_out  (found[i+1]),
			.lo_sel     (cell_lo[i]),
			.hi_sel     (cell_hi[i])
		);
	end

	// first level of the rank select tree, registered per group
	logic [SAMPLE_BITS-1:0] lo_grp_s1 [NGROUPS];
	logic [SAMPLE_BITS-1:0] hi_grp_s1 [NGROUPS];

	for (genvar g = 0; g < NGROUPS; g++) begin : g_grp
		logic [SAMPLE_BITS-1:0] lo_or [GROUP_SIZE+1];
		logic [SAMPLE_BITS-1:0] hi_or [GROUP_SIZE+1];

		assign lo_or[0] = '0;
		assign hi_or[0] = '0;

		for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_mem
			if (g * GROUP_SIZE + j < WINDOW_MAX) begin : g_on
				assign lo_or[j+1] = lo_or[j] | cell_lo[g*GROUP_SIZE+j];
				assign hi_or[j+1] = hi_or[j] | cell_hi[g*GROUP_SIZE+j];
			end else begin : g_off
				assign lo_or[j+1] = lo_or[j];
				assign hi_or[j+1] = hi_or[j];
			end
		end

		always_ff @(posedge clk) begin
			if (state_q == ST_SELECT) begin
				lo_grp_s1[g] <= lo_or[GROUP_SIZE];
				hi_grp_s1[g] <= hi_or[GROUP_SIZE];
			end
		end
	end

	// second level and the sum of the two middle values
	logic [SAMPLE_BITS-1:0]      lo_val, hi_val;
	logic signed [SAMPLE_BITS:0] med_sum;

	always_comb begin
		lo_val = '0;
		hi_val = '0;
		for (int g = 0; g < NGROUPS; g++) begin
			lo_val = lo_val | lo_grp_s1[g];
			hi_val = hi_val | hi_grp_s1[g];
		end
	end

	assign med_sum = $signed({lo_val[SAMPLE_BITS-1], lo_val})
	               + $signed({hi_val[SAMPLE_BITS-1], hi_val});

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INSERT;
			count_q  <= '0;
			oldest_q <= '0;
		end else begin
			case (state_q)
				ST_INSERT: begin
					if (in_fire) begin
						count_q  <= count_ins + CW'(1);
						oldest_q <= oldest_ins;
						state_q  <= ST_SELECT;
					end
				end
				ST_SELECT: begin
					state_q <= need_more ? ST_INSERT : ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_fire) begin
						count_q  <= count_q - CW'(1);
						oldest_q <= (oldest_q == PW'(WINDOW_MAX - 1)) ? '0 : (oldest_q + PW'(1));
						state_q  <= ST_INSERT;
					end
				end
				default: begin
					state_q <= ST_INSERT;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			median_q <= med_sum;
		end
	end

	assign out_valid = out_valid_q;
	assign median_x2 = median_q;

	// checks
	`SWM_ASSERT_IMPL(a_count_fits, clk, arst_n, state_q == ST_INSERT, count_q < CW'(WINDOW_MAX))
	`SWM_ASSERT_IMPL(a_oldest_held, clk, arst_n, state_q == ST_EMIT, found[WINDOW_MAX])
	`SWM_ASSERT_NEXT(a_insert_then_select, clk, arst_n, in_fire, state_q == ST_SELECT)
	`SWM_ASSERT_IMPL(a_result_from_emit, clk, arst_n, $rose(out_valid_q), $past(state_q == ST_EMIT))

endmodule
